[design/assert_macros.svh]
// assertion macros used by the hit test core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define CHK_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the cycle after
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cchit_pkg.sv]
// shared widths, types and cordic constants of the circle hit test
`timescale 1ns / 1ps

package cchit_pkg;

    // coordinate differences, ray ends included
    localparam int DW = 36;
    // signed operand of the shared multiplier
    localparam int OW = 74;
    // operand magnitude and product widths
    localparam int MW = 73;
    localparam int PW = 146;
    // accumulator, signed
    localparam int AW = 147;

    // multiplier digit handling
    localparam int MUL_DIG   = 4;
    localparam int MUL_BPAD  = 76;
    localparam int MUL_STEPS = MUL_BPAD / MUL_DIG;

    // cordic angles in 2^32 units per turn, start value x0 in 2^30 units
    localparam int CW           = 33;
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [CW-1:0] CORDIC_X0  = 33'sh026DD3B6A;
    localparam logic signed [CW-1:0] QUARTER_TURN = 33'sh040000000;
    localparam logic signed [CW-1:0] HALF_TURN    = 33'sh080000000;

    // register width of the ray count
    localparam int RCW = 7;

    typedef logic signed [DW-1:0] coord_t;
    typedef logic signed [OW-1:0] oper_t;
    typedef logic signed [CW-1:0] trig_t;

    function automatic trig_t atan_turn(input logic [4:0] idx);
        trig_t v;
        unique case (idx)
            5'd0:  v = 33'sh020000000;
            5'd1:  v = 33'sh012E4051E;
            5'd2:  v = 33'sh009FB385B;
            5'd3:  v = 33'sh0051111D4;
            5'd4:  v = 33'sh0028B0D43;
            5'd5:  v = 33'sh00145D7E1;
            5'd6:  v = 33'sh000A2F61E;
            5'd7:  v = 33'sh000517C55;
            5'd8:  v = 33'sh00028BE53;
            5'd9:  v = 33'sh000145F2F;
            5'd10: v = 33'sh0000A2F98;
            5'd11: v = 33'sh0000517CC;
            5'd12: v = 33'sh000028BE6;
            5'd13: v = 33'sh0000145F3;
            5'd14: v = 33'sh00000A2FA;
            5'd15: v = 33'sh00000517D;
            5'd16: v = 33'sh0000028BE;
            5'd17: v = 33'sh00000145F;
            5'd18: v = 33'sh000000A30;
            5'd19: v = 33'sh000000518;
            5'd20: v = 33'sh00000028C;
            5'd21: v = 33'sh000000146;
            5'd22: v = 33'sh0000000A3;
            5'd23: v = 33'sh000000051;
            5'd24: v = 33'sh000000029;
            5'd25: v = 33'sh000000014;
            5'd26: v = 33'sh00000000A;
            5'd27: v = 33'sh000000005;
            5'd28: v = 33'sh000000003;
            5'd29: v = 33'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[design/cchit_mul.sv]
// shared unsigned multiplier, four multiplier bits per cycle
`timescale 1ns / 1ps

module cchit_mul (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [cchit_pkg::MW-1:0] a,
    input  logic [cchit_pkg::MW-1:0] b,
    output logic                     done,
    output logic [cchit_pkg::PW-1:0] prod
);

    localparam int MW   = cchit_pkg::MW;
    localparam int BP   = cchit_pkg::MUL_BPAD;
    localparam int DG   = cchit_pkg::MUL_DIG;
    localparam int SW   = MW + 1 + DG;
    localparam int CNTW = $clog2(cchit_pkg::MUL_STEPS);

    logic [MW:0]      hi_reg, hi_next;
    logic [BP-1:0]    lo_reg, lo_next;
    logic [MW-1:0]    a_reg, a_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SW-1:0]    part;
    logic [SW-1:0]    sum;
    logic [MW+BP:0]   full;

    // a times the low digit of the remaining multiplier
    always_comb
    begin
        part = '0;
        for (int k = 0; k < DG; k++)
        begin
            if (lo_reg[k])
                part = part + (SW'(a_reg) << k);
        end
        sum = SW'(hi_reg) + part;
    end

    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            hi_next   = '0;
            lo_next   = BP'(b);
            a_next    = a;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[SW-1:DG];
            lo_next  = {sum[DG-1:0], lo_reg[BP-1:DG]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(cchit_pkg::MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        a_reg   <= a_next;
        cnt_reg <= cnt_next;
    end

    assign full = {hi_reg, lo_reg};
    assign prod = full[cchit_pkg::PW-1:0];
    assign done = done_reg;

endmodule

[design/cchit_div.sv]
// restoring divider for the ray angle offsets, one quotient bit per cycle
`timescale 1ns / 1ps

module cchit_div #(
    parameter int NW = 23
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [NW-1:0]             num,
    input  logic [cchit_pkg::RCW-1:0] den,
    output logic                      done,
    output logic [NW-1:0]             quot
);

    localparam int RW   = cchit_pkg::RCW;
    localparam int CNTW = $clog2(NW + 1);

    logic [RW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   q_reg, q_next;
    logic [RW-1:0]   den_reg, den_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW:0]     rem_sh;
    logic            qbit;

    always_comb
    begin
        rem_sh    = {rem_reg, q_reg[NW-1]};
        qbit      = rem_sh >= {1'b0, den_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? RW'(rem_sh - {1'b0, den_reg}) : rem_sh[RW-1:0];
            q_next   = {q_reg[NW-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[design/cchit_cordic.sv]
// iterative cordic for cosine and sine of a ray angle, one rotation per cycle
`timescale 1ns / 1ps

module cchit_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic                  done,
    output cchit_pkg::trig_t      cos_val,
    output cchit_pkg::trig_t      sin_val
);

    localparam int CW = cchit_pkg::CW;

    cchit_pkg::trig_t x_reg, x_next;
    cchit_pkg::trig_t y_reg, y_next;
    cchit_pkg::trig_t z_reg, z_next;
    logic             flip_reg, flip_next;
    logic [4:0]       step_reg, step_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [31:0]      z_turn;
    cchit_pkg::trig_t z_in;
    cchit_pkg::trig_t xs;
    cchit_pkg::trig_t ys;

    always_comb
    begin
        z_turn    = {angle, {(32 - ANGLE_BITS){1'b0}}};
        z_in      = CW'($signed(z_turn));
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // fold into the right half plane
            x_next    = cchit_pkg::CORDIC_X0;
            y_next    = '0;
            step_next = '0;
            busy_next = 1'b1;
            flip_next = 1'b0;
            z_next    = z_in;
            if (z_in > cchit_pkg::QUARTER_TURN)
            begin
                z_next    = z_in - cchit_pkg::HALF_TURN;
                flip_next = 1'b1;
            end
            else if (z_in < -cchit_pkg::QUARTER_TURN)
            begin
                z_next    = z_in + cchit_pkg::HALF_TURN;
                flip_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - cchit_pkg::atan_turn(step_reg);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + cchit_pkg::atan_turn(step_reg);
            end
            step_next = step_reg + 1'b1;
            if (step_reg == 5'(cchit_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        step_reg <= step_next;
    end

    assign done    = done_reg;
    assign cos_val = flip_reg ? -x_reg : x_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;

endmodule

[design/cone_circle_hit_test_core.sv]
// circle hit test for a segment or a cone of rays, with a shared multiplier
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+----------------------------
//  input   | in_valid, in_ready, item fields  | in_valid and in_ready high
//  output  | out_valid, out_ready, hit, degen | out_valid and out_ready high
//  config  | cfg_we, cfg_wdata                | cfg_we high
//
// every product goes through one 73x73 multiplier
// segment: up to 15 products; each cone ray adds a divide, a cordic run and
// 17 products; a cone runs up to ray_count rays, capped at MAX_RAYS,
// stopping at the first hit ray
// in_ready is high only while idle; a finished result waits in the output
// register and the next item can be taken while it waits
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cone_circle_hit_test_core #(
    parameter int ANGLE_BITS = 16,
    parameter int MAX_RAYS   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [31:0] start_x,
    input  logic [31:0] start_y,
    input  logic [31:0] end_x,
    input  logic [31:0] end_y,
    input  logic [15:0] heading,
    input  logic        use_heading,
    input  logic [15:0] sweep,
    input  logic [30:0] ray_length,
    input  logic [31:0] circle_x,
    input  logic [31:0] circle_y,
    input  logic [30:0] circle_radius,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic        degenerate,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    localparam int DW  = cchit_pkg::DW;
    localparam int OW  = cchit_pkg::OW;
    localparam int MW  = cchit_pkg::MW;
    localparam int PW  = cchit_pkg::PW;
    localparam int AW  = cchit_pkg::AW;
    localparam int RW  = cchit_pkg::RCW;
    localparam int AB  = ANGLE_BITS;
    localparam int NW  = AB + RW;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV_GO   = 4'd1;
    localparam logic [3:0] S_DIV_WAIT = 4'd2;
    localparam logic [3:0] S_COR_GO   = 4'd3;
    localparam logic [3:0] S_COR_WAIT = 4'd4;
    localparam logic [3:0] S_MUL_GO   = 4'd5;
    localparam logic [3:0] S_MUL_WAIT = 4'd6;
    localparam logic [3:0] S_RAY_PREP = 4'd7;
    localparam logic [3:0] S_END      = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    localparam logic [4:0] ST_LEN_X   = 5'd0;
    localparam logic [4:0] ST_LEN_Y   = 5'd1;
    localparam logic [4:0] ST_CR_A    = 5'd2;
    localparam logic [4:0] ST_CR_B    = 5'd3;
    localparam logic [4:0] ST_R2      = 5'd4;
    localparam logic [4:0] ST_CRSQ    = 5'd5;
    localparam logic [4:0] ST_INSIDE  = 5'd6;
    localparam logic [4:0] ST_DOTA_X  = 5'd7;
    localparam logic [4:0] ST_DOTA_Y  = 5'd8;
    localparam logic [4:0] ST_DOTB_X  = 5'd9;
    localparam logic [4:0] ST_DOTB_Y  = 5'd10;
    localparam logic [4:0] ST_AC_X    = 5'd11;
    localparam logic [4:0] ST_AC_Y    = 5'd12;
    localparam logic [4:0] ST_BC_X    = 5'd13;
    localparam logic [4:0] ST_BC_Y    = 5'd14;
    localparam logic [4:0] ST_SCALE_X = 5'd15;
    localparam logic [4:0] ST_SCALE_Y = 5'd16;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_SUB  = 2'd2;

    localparam logic [RW-1:0] RAY_COUNT_RESET = 7'd8;

    logic [3:0]        state_reg, state_next;
    logic [4:0]        step_reg, step_next;
    logic [RW-1:0]     ray_count_reg, ray_count_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_hit_next;
    logic              out_degen_reg, out_degen_next;

    logic              cmd_reg, cmd_next;
    logic              use_h_reg, use_h_next;
    cchit_pkg::coord_t sx_reg, sx_next;
    cchit_pkg::coord_t sy_reg, sy_next;
    cchit_pkg::coord_t cx_reg, cx_next;
    cchit_pkg::coord_t cy_reg, cy_next;
    cchit_pkg::coord_t dx_reg, dx_next;
    cchit_pkg::coord_t dy_reg, dy_next;
    cchit_pkg::coord_t ux_reg, ux_next;
    cchit_pkg::coord_t uy_reg, uy_next;
    cchit_pkg::coord_t vx_reg, vx_next;
    cchit_pkg::coord_t vy_reg, vy_next;
    logic [30:0]       rad_reg, rad_next;
    logic [30:0]       len_reg, len_next;
    logic [AB-1:0]     head_reg, head_next;
    logic [AB-1:0]     sweep_reg, sweep_next;
    logic [AB-1:0]     ang_reg, ang_next;
    logic [RW-1:0]     ray_n_reg, ray_n_next;
    logic [RW-1:0]     ray_idx_reg, ray_idx_next;
    logic [NW-1:0]     num_reg, num_next;
    cchit_pkg::trig_t  c_reg, c_next;
    cchit_pkg::trig_t  s_reg, s_next;
    logic              degen_reg, degen_next;
    logic              seg_hit_reg, seg_hit_next;

    logic [OW-1:0]     len2_reg, len2_next;
    cchit_pkg::oper_t  cr_reg, cr_next;
    logic [61:0]       r2_reg, r2_next;
    logic [PW-1:0]     crsq_reg, crsq_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic              dota_pos_reg, dota_pos_next;
    logic              dotb_pos_reg, dotb_pos_next;
    logic              fpos_reg, fpos_next;
    logic              fneg_reg, fneg_next;
    logic              mul_sign_reg, mul_sign_next;

    cchit_pkg::oper_t  op_a;
    cchit_pkg::oper_t  op_b;
    logic [1:0]        acc_mode;
    logic [MW-1:0]     mag_a;
    logic [MW-1:0]     mag_b;
    logic              mul_start;
    logic              mul_done;
    logic [PW-1:0]     mul_prod;
    logic signed [AW-1:0] prod_s;
    logic signed [AW-1:0] acc_new;
    logic [PW-1:0]     acc_low;
    logic              acc_pos;
    logic              acc_gt_r2;
    logic              acc_lt_r2;
    logic [63:0]       round_sum;
    cchit_pkg::coord_t scaled;
    logic              gpos;
    logic              gneg;
    logic              sd_pos;
    logic              sd_neg;
    logic              quad_same;
    logic              final_hit;

    logic              div_start;
    logic              div_done;
    logic [NW-1:0]     div_quot;
    logic              cor_start;
    logic              cor_done;
    cchit_pkg::trig_t  cor_cos;
    cchit_pkg::trig_t  cor_sin;
    logic [RW-1:0]     rays_sat;
    logic [AB-1:0]     in_head;
    logic [AB-1:0]     in_sweep;

    // operand selection for each product step
    always_comb
    begin
        op_a     = '0;
        op_b     = '0;
        acc_mode = MODE_LOAD;
        unique case (step_reg)
            ST_LEN_X:   begin op_a = OW'(dx_reg); op_b = OW'(dx_reg); end
            ST_LEN_Y:   begin op_a = OW'(dy_reg); op_b = OW'(dy_reg); acc_mode = MODE_ADD; end
            ST_CR_A:    begin op_a = OW'(dx_reg); op_b = OW'(uy_reg); end
            ST_CR_B:    begin op_a = OW'(dy_reg); op_b = OW'(ux_reg); acc_mode = MODE_SUB; end
            ST_R2:      begin op_a = OW'({1'b0, rad_reg}); op_b = OW'({1'b0, rad_reg}); end
            ST_CRSQ:    begin op_a = cr_reg; op_b = cr_reg; end
            ST_INSIDE:  begin op_a = OW'({1'b0, r2_reg}); op_b = len2_reg; end
            ST_DOTA_X:  begin op_a = OW'(dx_reg); op_b = OW'(ux_reg); end
            ST_DOTA_Y:  begin op_a = OW'(dy_reg); op_b = OW'(uy_reg); acc_mode = MODE_ADD; end
            ST_DOTB_X:  begin op_a = OW'(dx_reg); op_b = OW'(vx_reg); end
            ST_DOTB_Y:  begin op_a = OW'(dy_reg); op_b = OW'(vy_reg); acc_mode = MODE_ADD; end
            ST_AC_X:    begin op_a = OW'(ux_reg); op_b = OW'(ux_reg); end
            ST_AC_Y:    begin op_a = OW'(uy_reg); op_b = OW'(uy_reg); acc_mode = MODE_ADD; end
            ST_BC_X:    begin op_a = OW'(vx_reg); op_b = OW'(vx_reg); end
            ST_BC_Y:    begin op_a = OW'(vy_reg); op_b = OW'(vy_reg); acc_mode = MODE_ADD; end
            ST_SCALE_X: begin op_a = OW'({1'b0, len_reg}); op_b = OW'(c_reg); end
            ST_SCALE_Y: begin op_a = OW'({1'b0, len_reg}); op_b = OW'(s_reg); end
            default:    begin op_a = '0; op_b = '0; end
        endcase
        mag_a = op_a[OW-1] ? MW'(-op_a) : MW'(op_a);
        mag_b = op_b[OW-1] ? MW'(-op_b) : MW'(op_b);
    end

    // accumulate the signed product and derive the compare flags
    always_comb
    begin
        prod_s = mul_sign_reg ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
        case (acc_mode)
            MODE_ADD: acc_new = acc_reg + prod_s;
            MODE_SUB: acc_new = acc_reg - prod_s;
            default:  acc_new = prod_s;
        endcase
        acc_low   = acc_new[PW-1:0];
        acc_pos   = !acc_new[AW-1] && (acc_new != '0);
        acc_gt_r2 = acc_low > PW'(r2_reg);
        acc_lt_r2 = acc_low < PW'(r2_reg);
        // ray end offset, rounded half away from zero
        round_sum = mul_prod[63:0] + 64'(1 << 29);
        scaled    = mul_sign_reg ? -DW'(round_sum[63:30]) : DW'(round_sum[63:30]);
        gpos      = dotb_pos_reg && acc_gt_r2;
        gneg      = !dotb_pos_reg || acc_lt_r2;
        sd_pos    = !dx_reg[DW-1] && (dx_reg != '0);
        sd_neg    = dx_reg[DW-1];
        // quadrants 0 and 3 have equal top bits
        quad_same = ang_reg[AB-1] == ang_reg[AB-2];
        if (quad_same)
            final_hit = (sd_pos && fpos_reg && gpos) || (sd_neg && fneg_reg && gneg);
        else
            final_hit = (sd_pos && fneg_reg && gneg) || (sd_neg && fpos_reg && gpos);
    end

    assign rays_sat = (9'(ray_count_reg) > 9'(MAX_RAYS)) ? RW'(MAX_RAYS) : ray_count_reg;
    assign in_head  = AB'(heading);
    assign in_sweep = AB'(sweep);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        ray_count_next = cfg_we ? cfg_wdata : ray_count_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_degen_next = out_degen_reg;
        cmd_next       = cmd_reg;
        use_h_next     = use_h_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        ux_next        = ux_reg;
        uy_next        = uy_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        rad_next       = rad_reg;
        len_next       = len_reg;
        head_next      = head_reg;
        sweep_next     = sweep_reg;
        ang_next       = ang_reg;
        ray_n_next     = ray_n_reg;
        ray_idx_next   = ray_idx_reg;
        num_next       = num_reg;
        c_next         = c_reg;
        s_next         = s_reg;
        degen_next     = degen_reg;
        seg_hit_next   = seg_hit_reg;
        len2_next      = len2_reg;
        cr_next        = cr_reg;
        r2_next        = r2_reg;
        crsq_next      = crsq_reg;
        acc_next       = acc_reg;
        dota_pos_next  = dota_pos_reg;
        dotb_pos_next  = dotb_pos_reg;
        fpos_next      = fpos_reg;
        fneg_next      = fneg_reg;
        mul_sign_next  = mul_sign_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        cor_start      = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = cmd;
                    use_h_next   = cmd || use_heading;
                    sx_next      = DW'($signed(start_x));
                    sy_next      = DW'($signed(start_y));
                    cx_next      = DW'($signed(circle_x));
                    cy_next      = DW'($signed(circle_y));
                    ux_next      = DW'($signed(circle_x)) - DW'($signed(start_x));
                    uy_next      = DW'($signed(circle_y)) - DW'($signed(start_y));
                    dx_next      = DW'($signed(end_x)) - DW'($signed(start_x));
                    dy_next      = DW'($signed(end_y)) - DW'($signed(start_y));
                    vx_next      = DW'($signed(end_x)) - DW'($signed(circle_x));
                    vy_next      = DW'($signed(end_y)) - DW'($signed(circle_y));
                    rad_next     = circle_radius;
                    len_next     = ray_length;
                    head_next    = in_head;
                    sweep_next   = in_sweep;
                    ang_next     = in_head;
                    degen_next   = 1'b0;
                    seg_hit_next = 1'b0;
                    ray_n_next   = rays_sat;
                    ray_idx_next = '0;
                    num_next     = '0;
                    step_next    = ST_LEN_X;
                    if (!cmd)
                        state_next = S_MUL_GO;
                    else if (rays_sat == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    ang_next   = head_reg - (sweep_reg >> 1) + div_quot[AB-1:0];
                    state_next = S_COR_GO;
                end
            end
            S_COR_GO:
            begin
                cor_start  = 1'b1;
                state_next = S_COR_WAIT;
            end
            S_COR_WAIT:
            begin
                if (cor_done)
                begin
                    c_next     = cor_cos;
                    s_next     = cor_sin;
                    step_next  = ST_SCALE_X;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                mul_start     = 1'b1;
                mul_sign_next = op_a[OW-1] ^ op_b[OW-1];
                state_next    = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    acc_next   = acc_new;
                    step_next  = step_reg + 1'b1;
                    state_next = S_MUL_GO;
                    case (step_reg)
                        ST_LEN_Y:
                        begin
                            len2_next = acc_new[OW-1:0];
                            if (acc_new == '0)
                            begin
                                degen_next   = 1'b1;
                                seg_hit_next = 1'b0;
                                state_next   = S_END;
                            end
                        end
                        ST_CR_B:   cr_next   = acc_new[OW-1:0];
                        ST_R2:     r2_next   = acc_new[61:0];
                        ST_CRSQ:   crsq_next = acc_low;
                        ST_INSIDE:
                        begin
                            // strictly inside, a tangent misses
                            if (!(crsq_reg < acc_low))
                            begin
                                seg_hit_next = 1'b0;
                                state_next   = S_END;
                            end
                            else if (!use_h_reg)
                            begin
                                seg_hit_next = 1'b1;
                                state_next   = S_END;
                            end
                        end
                        ST_DOTA_Y: dota_pos_next = acc_pos;
                        ST_DOTB_Y: dotb_pos_next = acc_pos;
                        ST_AC_Y:
                        begin
                            fpos_next = dota_pos_reg && acc_gt_r2;
                            fneg_next = !dota_pos_reg || acc_lt_r2;
                        end
                        ST_BC_Y:
                        begin
                            seg_hit_next = final_hit;
                            state_next   = S_END;
                        end
                        ST_SCALE_X: dx_next = scaled;
                        ST_SCALE_Y:
                        begin
                            dy_next    = scaled;
                            step_next  = ST_LEN_X;
                            state_next = S_RAY_PREP;
                        end
                        default: ;
                    endcase
                end
            end
            S_RAY_PREP:
            begin
                vx_next    = sx_reg + dx_reg - cx_reg;
                vy_next    = sy_reg + dy_reg - cy_reg;
                step_next  = ST_LEN_X;
                state_next = S_MUL_GO;
            end
            S_END:
            begin
                if (!cmd_reg || seg_hit_reg || (ray_idx_reg + 1'b1 == ray_n_reg))
                    state_next = S_DONE;
                else
                begin
                    ray_idx_next = ray_idx_reg + 1'b1;
                    num_next     = num_reg + NW'(sweep_reg);
                    state_next   = S_DIV_GO;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = seg_hit_reg;
                    out_degen_next = degen_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_LEN_X;
            ray_count_reg <= RAY_COUNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ray_count_reg <= ray_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg   <= out_hit_next;
        out_degen_reg <= out_degen_next;
        cmd_reg       <= cmd_next;
        use_h_reg     <= use_h_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        ux_reg        <= ux_next;
        uy_reg        <= uy_next;
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        rad_reg       <= rad_next;
        len_reg       <= len_next;
        head_reg      <= head_next;
        sweep_reg     <= sweep_next;
        ang_reg       <= ang_next;
        ray_n_reg     <= ray_n_next;
        ray_idx_reg   <= ray_idx_next;
        num_reg       <= num_next;
        c_reg         <= c_next;
        s_reg         <= s_next;
        degen_reg     <= degen_next;
        seg_hit_reg   <= seg_hit_next;
        len2_reg      <= len2_next;
        cr_reg        <= cr_next;
        r2_reg        <= r2_next;
        crsq_reg      <= crsq_next;
        acc_reg       <= acc_next;
        dota_pos_reg  <= dota_pos_next;
        dotb_pos_reg  <= dotb_pos_next;
        fpos_reg      <= fpos_next;
        fneg_reg      <= fneg_next;
        mul_sign_reg  <= mul_sign_next;
    end

    cchit_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mag_a),
        .b     (mag_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    cchit_div #(
        .NW (NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (ray_n_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    cchit_cordic #(
        .ANGLE_BITS (AB)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (ang_reg),
        .done    (cor_done),
        .cos_val (cor_cos),
        .sin_val (cor_sin)
    );

    assign in_ready   = state_reg == S_IDLE;
    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign degenerate = out_degen_reg;

    // ray index stays below the ray count while a ray angle is computed
    `CHK_HOLDS(a_ray_idx_range, (state_reg != S_DIV_WAIT) || (ray_idx_reg < ray_n_reg), "ray index out of range")
    // a transfer on the input leaves idle
    `CHK_NEXT(a_accept_busy, in_valid && in_ready, state_reg != S_IDLE, "item accepted but block idle")
    // step sequence never runs past the last scaling step
    `CHK_HOLDS(a_step_range, step_reg <= ST_SCALE_Y, "product step out of range")

endmodule
